// File: rtl/tssa_pkg.sv
package tssa_pkg;

    // Configuration register width (capacity)
    localparam int CAP_W = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Opcodes
    localparam logic [2:0] OP_PUSH_L = 3'd0;
    localparam logic [2:0] OP_PUSH_R = 3'd1;
    localparam logic [2:0] OP_POP_L  = 3'd2;
    localparam logic [2:0] OP_POP_R  = 3'd3;
    localparam logic [2:0] OP_PEEK_L = 3'd4;
    localparam logic [2:0] OP_PEEK_R = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] push_value;
    } op_word_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } res_word_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // latch incoming word
        logic exec;       // evaluate op, update counts, access store
        logic finish;     // load result register
        logic cfg_write;  // capacity write handshake
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;   // result register can take a word this cycle
    } dp_stat_t;

endpackage

// File: rtl/tssa_ctrl.sv
module tssa_ctrl
    import tssa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    input  logic     cfg_valid,
    input  dp_stat_t stat,
    output logic     op_stall,
    output logic     cfg_ready,
    output dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign op_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign cmd.accept    = op_valid && (state_reg == S_IDLE);
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.finish    = (state_reg == S_FIN) && stat.out_free;
    assign cmd.cfg_write = cfg_valid && (state_reg == S_IDLE);

endmodule

// File: rtl/tssa_dpath.sv
module tssa_dpath
    import tssa_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  op_word_t         op_word,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             res_stall,
    output dp_stat_t         stat,
    output logic             res_valid,
    output res_word_t        res_word
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [2:0]            op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [CAP_W-1:0]      cap_next;
    logic [CNT_W-1:0]      left_reg;
    logic [CNT_W-1:0]      left_next;
    logic [CNT_W-1:0]      right_reg;
    logic [CNT_W-1:0]      right_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  rd_ok_reg;
    logic                  rd_ok_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  res_valid_reg;
    res_word_t             res_word_reg;

    logic [CMP_W-1:0]      eff_cap;
    logic [CMP_W-1:0]      left_ext;
    logic [CMP_W-1:0]      right_ext;
    logic [CMP_W:0]        used;
    logic [CMP_W-1:0]      rtop_free;
    logic [CMP_W-1:0]      rtop_full;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_addr;

    // Capacity saturates at the physical depth
    assign eff_cap   = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign left_ext  = CMP_W'(left_reg);
    assign right_ext = CMP_W'(right_reg);
    assign used      = {1'b0, left_ext} + {1'b0, right_ext};
    assign rtop_free = eff_cap - right_ext - CMP_W'(1);
    assign rtop_full = eff_cap - right_ext;

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = left_reg[ADDR_W-1:0];
        if (cmd.exec)
        begin
            status_next = ST_OK;
            rd_ok_next  = 1'b0;
            unique case (op_reg) inside
                OP_PUSH_L, OP_PUSH_R:
                begin
                    if (used >= {1'b0, eff_cap})
                    begin
                        status_next = ST_OVER;
                    end
                    else if (op_reg == OP_PUSH_L)
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = left_reg[ADDR_W-1:0];
                        left_next = left_reg + CNT_W'(1);
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = rtop_free[ADDR_W-1:0];
                        right_next = right_reg + CNT_W'(1);
                    end
                end
                OP_POP_L, OP_PEEK_L:
                begin
                    if (left_reg == '0)
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        rd_ok_next = 1'b1;
                        mem_addr   = left_reg[ADDR_W-1:0] - ADDR_W'(1);
                        if (op_reg == OP_POP_L)
                        begin
                            left_next = left_reg - CNT_W'(1);
                        end
                    end
                end
                OP_POP_R, OP_PEEK_R:
                begin
                    if ((right_reg == '0) || (right_ext > eff_cap))
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        rd_ok_next = 1'b1;
                        mem_addr   = rtop_full[ADDR_W-1:0];
                        if (op_reg == OP_POP_R)
                        begin
                            right_next = right_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Capacity only moves while both stacks are empty
    always_comb
    begin
        cap_next = cap_reg;
        if (cmd.cfg_write && (left_reg == '0) && (right_reg == '0))
        begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            left_reg      <= '0;
            right_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op_word.opcode;
            val_reg <= DATA_WIDTH'(op_word.push_value);
        end
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
        if (cmd.finish)
        begin
            res_word_reg.result_value <= rd_ok_reg ? 32'(rd_data_reg) : 32'd0;
            res_word_reg.status       <= status_reg;
        end
    end

    // Shared store: one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= val_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign stat.out_free = !res_valid_reg || !res_stall;
    assign res_valid     = res_valid_reg;
    assign res_word      = res_word_reg;

endmodule

// File: rtl/two_stacks_shared_array.sv
// Two LIFO stacks sharing one store of DEPTH words of DATA_WIDTH bits.
// The left stack grows up from entry 0, the right one down from capacity-1.
// Operation channel (op_valid/op_stall/op_word): one word per operation,
//   accepted at a clock edge with op_valid high and op_stall low.
// Result channel (res_valid/res_stall/res_word): exactly one word per
//   operation, in order; res_word holds steady while res_stall is high.
// Capacity channel (cfg_valid/cfg_ready/cfg_data): written when both are
//   high; ignored unless both stacks are empty, saturates at DEPTH.
// After acceptance each operation passes the execute and result-load
//   steps; res_word and res_valid are registered at the result load.
// The sequencer walks accept, execute (store write or registered read),
//   and result load for each operation, and the store's read register
//   sets the execute-to-result step. A new operation is taken only once
//   the sequencer is back at accept, after the result load.
// The result register frees the sequencer: a new operation is taken while
//   a finished result still waits. A stalled receiver holds the sequencer
//   at its result step only when a second result is ready behind it.
// Reset: both counts clear, capacity returns to 1024, no result is pending.
//   Store contents are not cleared; no entry is read before being written.
module two_stacks_shared_array
    import tssa_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_stall,
    input  op_word_t         op_word,
    output logic             res_valid,
    input  logic             res_stall,
    output res_word_t        res_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    dp_cmd_t  cmd;   // sequencer steps to the datapath
    dp_stat_t stat;  // result register availability back

    tssa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .op_stall  (op_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    tssa_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op_word   (op_word),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .stat      (stat),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

endmodule

// File: rtl/tssa_chk.sv
module tssa_chk
    import tssa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             op_valid,
    input logic             op_stall,
    input op_word_t         op_word,
    input logic             res_valid,
    input logic             res_stall,
    input res_word_t        res_word,
    input logic             cfg_ready
);

    // Held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed under stall");

    // Error results carry a zero word; pushes also return zero, but only errors are checked here
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.status != ST_OK) |-> res_word.result_value == 32'd0)
        else $error("nonzero value with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.status == ST_OK) || (res_word.status == ST_OVER)
                      || (res_word.status == ST_UNDER))
        else $error("undefined status code");

    // One operation in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_stall |=> op_stall && !cfg_ready)
        else $error("new word or config taken while operation in flight");

    // Stalled operation word stays put
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_stall |=> op_valid && $stable(op_word))
        else $error("operation word changed under stall");

endmodule

bind two_stacks_shared_array tssa_chk u_tssa_chk (.*);
